// File: rtl/core/vn1d_pkg.sv
`default_nettype none

package vn1d_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COORD_W     = 32;
    localparam int OUT_W       = FRAC_BITS + 5;

    localparam int T_W         = FRAC_BITS + 1;
    localparam int K_W         = FRAC_BITS + 3;
    localparam int OMS_W       = FRAC_BITS + 4;
    localparam int G_W         = 31;
    localparam int PROD_W      = G_W + OMS_W;
    localparam int V_W         = PROD_W + 1;
    localparam int BLEND_SHIFT = 30;
    localparam int R_W         = V_W - BLEND_SHIFT;

    localparam int N_STAGES    = 6;

    localparam int HASH_SHIFT  = 13;

    typedef logic [31:0] t_word;

    localparam t_word HASH_MUL   = 32'd15731;
    localparam t_word HASH_ADD_A = 32'd789221;
    localparam t_word HASH_ADD_B = 32'd1376312589;

    localparam logic signed [OMS_W-1:0] ONE_S       = OMS_W'(1 << FRAC_BITS);
    localparam logic signed [OMS_W-1:0] THREE_ONE_S = OMS_W'(3 << FRAC_BITS);

    localparam logic [K_W-1:0] K_LO = K_W'(1 << FRAC_BITS);
    localparam logic [K_W-1:0] K_HI = K_W'(5 << FRAC_BITS);

    localparam logic signed [R_W-1:0] SAT_HI = R_W'((1 << (FRAC_BITS + 4)) - 1);
    localparam logic signed [R_W-1:0] SAT_LO = -R_W'(1 << (FRAC_BITS + 4));

    function automatic t_word hash_premix(input t_word x);
        hash_premix = x ^ (x << HASH_SHIFT);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/value_noise_1d_unit.sv
// One-dimensional lattice value noise with a smoothstep fade. Each transfer on
// the input channel carries a signed Q15.16 coordinate; each output transfer
// carries one signed Q4.16 noise sample, saturated, in the same order. The
// block is a six-stage pipeline and takes one coordinate per clock while
// o_stall is low. o_valid is the valid flag of the last stage. The depth is
// set by the lattice hash, whose three chained 32-bit multiplies each get a
// stage, followed by the blend multiply and the final add and clamp. Empty
// stages fill while the output is stalled, so o_stall rises only when all six
// stages hold a sample. Reset clears the pipeline; there is no configuration.
`default_nettype none

module value_noise_1d_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic signed [vn1d_pkg::COORD_W-1:0] i_coordinate,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic signed [vn1d_pkg::OUT_W-1:0]       o_noise_value
);

    localparam int F = vn1d_pkg::FRAC_BITS;

    logic [vn1d_pkg::N_STAGES-1:0] r_vld;
    logic [vn1d_pkg::N_STAGES-1:0] en;

    // stage enables: a stage loads when empty or when its successor moves
    always_comb begin
        en[vn1d_pkg::N_STAGES-1] = ~r_vld[vn1d_pkg::N_STAGES-1] | ~i_stall;
        for (int k = vn1d_pkg::N_STAGES - 2; k >= 0; k--) begin
            en[k] = ~r_vld[k] | en[k+1];
        end
    end

    assign o_stall = ~en[0];
    assign o_valid = r_vld[vn1d_pkg::N_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < vn1d_pkg::N_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: lattice index (truncate toward zero), fraction, hash premix
    logic                          n_neg_adj;
    vn1d_pkg::t_word               n_xi;
    vn1d_pkg::t_word               r_i0_1, r_i1_1;
    logic signed [vn1d_pkg::T_W-1:0] r_t_1;

    assign n_neg_adj = i_coordinate[vn1d_pkg::COORD_W-1] & (|i_coordinate[F-1:0]);
    assign n_xi = {{F{i_coordinate[vn1d_pkg::COORD_W-1]}},
                   i_coordinate[vn1d_pkg::COORD_W-1:F]} + 32'(n_neg_adj);

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_i0_1 <= vn1d_pkg::hash_premix(n_xi);
            r_i1_1 <= vn1d_pkg::hash_premix(n_xi + 32'd1);
            r_t_1  <= {n_neg_adj, i_coordinate[F-1:0]};
        end
    end

    // stage 2: i*i, t*t
    logic signed [2*vn1d_pkg::T_W-1:0] n_tsq;
    vn1d_pkg::t_word                   r_i0_2, r_i1_2, r_sq0_2, r_sq1_2;
    logic signed [vn1d_pkg::T_W-1:0]   r_t_2;
    logic [F-1:0]                      r_t2_2;

    assign n_tsq = r_t_1 * r_t_1;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_i0_2  <= r_i0_1;
            r_i1_2  <= r_i1_1;
            r_sq0_2 <= r_i0_1 * r_i0_1;
            r_sq1_2 <= r_i1_1 * r_i1_1;
            r_t_2   <= r_t_1;
            r_t2_2  <= n_tsq[2*F-1:F];
        end
    end

    // stage 3: i*i*15731 + 789221, fade slope 3 - 2t
    logic signed [vn1d_pkg::OMS_W-1:0] n_k;
    vn1d_pkg::t_word                   r_i0_3, r_i1_3, r_p0_3, r_p1_3;
    logic [F-1:0]                      r_t2_3;
    logic [vn1d_pkg::K_W-1:0]          r_k_3;

    assign n_k = vn1d_pkg::THREE_ONE_S -
                 ({{(vn1d_pkg::OMS_W - vn1d_pkg::T_W){r_t_2[vn1d_pkg::T_W-1]}}, r_t_2} <<< 1);

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_i0_3 <= r_i0_2;
            r_i1_3 <= r_i1_2;
            r_p0_3 <= r_sq0_2 * vn1d_pkg::HASH_MUL + vn1d_pkg::HASH_ADD_A;
            r_p1_3 <= r_sq1_2 * vn1d_pkg::HASH_MUL + vn1d_pkg::HASH_ADD_A;
            r_t2_3 <= r_t2_2;
            r_k_3  <= n_k[vn1d_pkg::K_W-1:0];
        end
    end

    // stage 4: finish hash, map to Q1.30 minus one; smoothstep weight
    vn1d_pkg::t_word                   n_h0, n_h1;
    logic [F+vn1d_pkg::K_W-1:0]        n_sprod;
    logic signed [vn1d_pkg::G_W-1:0]   r_g0_4, r_g1_4;
    logic [vn1d_pkg::K_W-1:0]          r_s_4;

    assign n_h0    = r_i0_3 * r_p0_3 + vn1d_pkg::HASH_ADD_B;
    assign n_h1    = r_i1_3 * r_p1_3 + vn1d_pkg::HASH_ADD_B;
    assign n_sprod = r_t2_3 * r_k_3;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_g0_4 <= {~n_h0[30], n_h0[29:0]};
            r_g1_4 <= {~n_h1[30], n_h1[29:0]};
            r_s_4  <= n_sprod[F+vn1d_pkg::K_W-1:F];
        end
    end

    // stage 5: blend products
    logic signed [vn1d_pkg::OMS_W-1:0]  n_oms;
    logic signed [vn1d_pkg::PROD_W-1:0] r_m0_5, r_m1_5;

    assign n_oms = vn1d_pkg::ONE_S - $signed({1'b0, r_s_4});

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_m0_5 <= r_g0_4 * n_oms;
            r_m1_5 <= r_g1_4 * $signed({1'b0, r_s_4});
        end
    end

    // stage 6: sum, floor shift, clamp
    logic signed [vn1d_pkg::V_W-1:0] n_v;
    logic signed [vn1d_pkg::R_W-1:0] n_r, n_rc;
    logic signed [vn1d_pkg::OUT_W-1:0] r_noise_6;

    assign n_v = {r_m0_5[vn1d_pkg::PROD_W-1], r_m0_5} + {r_m1_5[vn1d_pkg::PROD_W-1], r_m1_5};
    assign n_r = n_v[vn1d_pkg::V_W-1:vn1d_pkg::BLEND_SHIFT];

    always_comb begin
        if (n_r > vn1d_pkg::SAT_HI) begin
            n_rc = vn1d_pkg::SAT_HI;
        end else if (n_r < vn1d_pkg::SAT_LO) begin
            n_rc = vn1d_pkg::SAT_LO;
        end else begin
            n_rc = n_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_noise_6 <= n_rc[vn1d_pkg::OUT_W-1:0];
        end
    end

    assign o_noise_value = r_noise_6;

    // backpressure reaches the input only with a full pipeline
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled with an empty stage");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid output right after reset");

    a_fade_slope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_k_3 > vn1d_pkg::K_LO) && (r_k_3 < vn1d_pkg::K_HI))
        else $error("fade slope out of range");

endmodule

`default_nettype wire

// File: test/value_noise_1d_checker.sv
`timescale 1ns / 100ps

module value_noise_1d_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    input  wire logic                                i_in_stall,
    input  wire logic signed [vn1d_pkg::COORD_W-1:0] i_coordinate,
    input  wire logic                                i_out_valid,
    input  wire logic                                i_out_stall,
    input  wire logic signed [vn1d_pkg::OUT_W-1:0]   i_noise_value,
    output int                                       o_mismatches,
    output int                                       o_outstanding
);

    localparam int F = vn1d_pkg::FRAC_BITS;

    typedef struct {
        logic signed [vn1d_pkg::COORD_W-1:0] coordinate;
        logic signed [vn1d_pkg::OUT_W-1:0]   noise;
    } t_noise_sample;

    t_noise_sample expected_noise [$];
    t_noise_sample oldest;
    t_noise_sample fresh;
    int            mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    // Integer lattice hash, read as a Q1.30 level in [-1, 1).
    function automatic longint lattice_level(input vn1d_pkg::t_word point);
        vn1d_pkg::t_word mixed;
        vn1d_pkg::t_word hashed;
        mixed  = point ^ (point << vn1d_pkg::HASH_SHIFT);
        hashed = mixed * (mixed * mixed * vn1d_pkg::HASH_MUL + vn1d_pkg::HASH_ADD_A)
                 + vn1d_pkg::HASH_ADD_B;
        hashed[31] = 1'b0;
        return longint'(hashed) - (longint'(1) << 30);
    endfunction

    function automatic logic signed [vn1d_pkg::OUT_W-1:0] noise_at(
        input logic signed [vn1d_pkg::COORD_W-1:0] coordinate
    );
        longint one;
        longint c;
        longint mag;
        longint xi;
        longint frac;
        longint frac_sq;
        longint fade;
        longint g0;
        longint g1;
        longint blend;
        longint level;
        longint hi;
        longint lo;
        one   = longint'(1) << F;
        c     = coordinate;
        mag   = (c < 0) ? -c : c;
        xi    = (c < 0) ? -(mag >>> F) : (mag >>> F);
        frac  = c - xi * one;
        g0    = lattice_level(vn1d_pkg::t_word'(xi));
        g1    = lattice_level(vn1d_pkg::t_word'(xi + 1));
        frac_sq = (frac * frac) >>> F;
        fade    = (frac_sq * (3 * one - 2 * frac)) >>> F;
        blend   = g0 * (one - fade) + g1 * fade;
        level   = blend >>> 30;
        hi      = (longint'(1) << (F + 4)) - 1;
        lo      = -(longint'(1) << (F + 4));
        if (level > hi) begin
            level = hi;
        end
        if (level < lo) begin
            level = lo;
        end
        return level[vn1d_pkg::OUT_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_noise.size() == 0) begin
                    $display("%0t: unexpected noise transfer, expected none, got %0d",
                             $time, i_noise_value);
                    mismatch_count++;
                end else begin
                    oldest = expected_noise.pop_front();
                    if (i_noise_value !== oldest.noise) begin
                        $display("%0t: noise_value for coordinate %h: expected %0d, got %0d",
                                 $time, oldest.coordinate, oldest.noise, i_noise_value);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                fresh.coordinate = i_coordinate;
                fresh.noise      = noise_at(i_coordinate);
                expected_noise.insert(expected_noise.size(), fresh);
            end
        end
        o_outstanding <= expected_noise.size();
    end

endmodule

// File: test/tb_value_noise_1d_unit.sv
`timescale 1ns / 100ps

module tb_value_noise_1d_unit;

    localparam int RANDOM_ITEMS = 2000;
    localparam int N_CORNERS    = 22;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                coord_valid = 1'b0;
    logic signed [vn1d_pkg::COORD_W-1:0] coordinate = '0;
    logic                                noise_stall = 1'b0;
    wire logic                           coord_stall;
    wire logic                           noise_valid;
    wire logic signed [vn1d_pkg::OUT_W-1:0] noise_value;
    int                                  mismatches;
    int                                  outstanding;

    logic signed [vn1d_pkg::COORD_W-1:0] corner_coordinates [N_CORNERS] = '{
        32'sh0000_0000, 32'sh0000_0001, 32'shffff_ffff, 32'sh7fff_ffff,
        32'sh8000_0000, 32'sh0000_ffff, 32'sh0001_0000, 32'shffff_0000,
        32'shffff_0001, 32'sh0000_8000, 32'shffff_8000, 32'sh7fff_0000,
        32'sh7fff_8000, 32'sh8000_8000, 32'sh8000_0001, 32'sh0001_ffff,
        32'shfffe_0001, 32'sh1234_5678, 32'shedcb_a988, 32'sh0000_7fff,
        32'shffff_8001, 32'sh5555_aaaa
    };

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    value_noise_1d_unit u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (coord_valid),
        .o_stall       (coord_stall),
        .i_coordinate  (coordinate),
        .o_valid       (noise_valid),
        .i_stall       (noise_stall),
        .o_noise_value (noise_value)
    );

    value_noise_1d_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (coord_valid),
        .i_in_stall    (coord_stall),
        .i_coordinate  (coordinate),
        .i_out_valid   (noise_valid),
        .i_out_stall   (noise_stall),
        .i_noise_value (noise_value),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Random wait, with occasional runs of back-to-back transfers.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if ($urandom_range(0, 2) == 0) begin
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic logic signed [vn1d_pkg::COORD_W-1:0] draw_coordinate();
        logic signed [vn1d_pkg::COORD_W-1:0] value;
        int                                  pick;
        pick  = $urandom_range(0, 7);
        value = $urandom;
        case (pick)
            3, 4: begin
                value = int'($urandom_range(0, 524288)) - 262144;
            end
            5: begin
                value[30:20] = value[31] ? 11'h000 : 11'h7ff;
            end
            6: begin
                value[15:0] = $urandom_range(0, 1) ? 16'hffff : 16'h0001;
            end
            7: begin
                value[15:0] = 16'h0000;
            end
            default: begin
            end
        endcase
        return value;
    endfunction

    task automatic send_coordinate(input logic signed [vn1d_pkg::COORD_W-1:0] value,
                                   inout int calm_left);
        int gap;
        gap = draw_wait(calm_left);
        if (gap > 0) begin
            coord_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        coord_valid <= 1'b1;
        coordinate  <= value;
        do @(posedge clk); while (coord_stall);
    endtask

    initial begin
        int in_calm;
        in_calm = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        foreach (corner_coordinates[k]) begin
            send_coordinate(corner_coordinates[k], in_calm);
        end
        repeat (RANDOM_ITEMS) begin
            send_coordinate(draw_coordinate(), in_calm);
        end
        coord_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4 * vn1d_pkg::N_STAGES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Receiver; two long hold-offs let the pipeline fill and push back.
    initial begin
        int out_calm;
        int taken;
        int hold;
        out_calm = 0;
        taken    = 0;
        forever begin
            if (taken == 300 || taken == 1400) begin
                hold = 150;
            end else begin
                hold = draw_wait(out_calm);
            end
            if (hold > 0) begin
                noise_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            noise_stall <= 1'b0;
            do @(posedge clk); while (!noise_valid);
            taken++;
        end
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
